// File: rtl/core/mpbf_pkg.sv
package mpbf_pkg;

    localparam logic [2:0] REQ_ALLOC   = 3'd0;
    localparam logic [2:0] REQ_WRITE   = 3'd1;
    localparam logic [2:0] REQ_READ    = 3'd2;
    localparam logic [2:0] REQ_ACQUIRE = 3'd3;
    localparam logic [2:0] REQ_RELEASE = 3'd4;

    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_BLOCK   = 3'd1;
    localparam logic [2:0] STS_BROKEN  = 3'd2;
    localparam logic [2:0] STS_EOF     = 3'd3;
    localparam logic [2:0] STS_NOFREE  = 3'd4;
    localparam logic [2:0] STS_NOTUSED = 3'd5;

    localparam logic [7:0] END_MAX = 8'd255;

    typedef struct packed {
        logic [2:0] req_type;
        logic [1:0] pipe_index;
        logic       end_is_writer;
        logic [7:0] write_data;
    } mpbf_req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] read_data;
        logic [1:0] pipe_out;
        logic       wake_readers;
        logic       wake_writers;
    } mpbf_rsp_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } mpbf_mem_cmd_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_DONE
    } mpbf_fsm_t;

endpackage

// File: rtl/core/multi_pipe_byte_fifo.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  mpbf_req_t: request type, pipe, end kind, byte
// rsp       out        rsp_valid/rsp_stall  mpbf_rsp_t: status, byte, pipe, wake flags
//
// Each transaction is captured in IDLE, updates the pipe table and accesses the byte
// memory in EXEC, and loads the response register in DONE. The byte memory has one
// port with a registered read. A new request is taken as soon as the previous response
// has been loaded, even while that response is stalled; a stalled response holds the
// next one in its DONE state. Reset frees all pipes at once; the byte memory is not
// cleared.
module multi_pipe_byte_fifo
    import mpbf_pkg::*;
#(
    parameter int PIPE_COUNT = 4,
    parameter int PIPE_DEPTH = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  mpbf_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output mpbf_rsp_t rsp
);

    localparam int MEM_DEPTH = PIPE_COUNT * PIPE_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    mpbf_mem_cmd_t     mem_cmd;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata;

    mpbf_ctrl #(
        .PIPE_COUNT (PIPE_COUNT),
        .PIPE_DEPTH (PIPE_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .mem_cmd   (mem_cmd),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    mpbf_store #(
        .MEM_DEPTH (MEM_DEPTH),
        .ADDR_W    (ADDR_W)
    ) u_store (
        .clk   (clk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

// File: rtl/core/mpbf_store.sv
module mpbf_store
    import mpbf_pkg::*;
#(
    parameter int MEM_DEPTH = 4096,
    parameter int ADDR_W    = 12
)
(
    input  logic                clk,
    input  mpbf_mem_cmd_t       cmd,
    input  logic [ADDR_W-1:0]   addr,
    input  logic [7:0]          wdata,
    output logic [7:0]          rdata
);

    logic [7:0] mem [MEM_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/mpbf_ctrl.sv
module mpbf_ctrl
    import mpbf_pkg::*;
#(
    parameter int PIPE_COUNT = 4,
    parameter int PIPE_DEPTH = 1024,
    parameter int ADDR_W     = 12
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  mpbf_req_t           req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output mpbf_rsp_t           rsp,
    output mpbf_mem_cmd_t       mem_cmd,
    output logic [ADDR_W-1:0]   mem_addr,
    output logic [7:0]          mem_wdata,
    input  logic [7:0]          mem_rdata
);

    localparam int PIDX_W = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
    localparam int PTR_W  = $clog2(PIPE_DEPTH);
    localparam int FILL_W = $clog2(PIPE_DEPTH + 1);

    mpbf_fsm_t state_reg, state_next;
    mpbf_req_t req_hold_reg;
    mpbf_rsp_t res_reg;
    logic      rd_ok_reg;
    mpbf_rsp_t rsp_reg;
    logic      rsp_valid_reg;

    logic [PTR_W-1:0]  head_reg   [PIPE_COUNT];
    logic [PTR_W-1:0]  tail_reg   [PIPE_COUNT];
    logic [FILL_W-1:0] fill_reg   [PIPE_COUNT];
    logic [7:0]        rcnt_reg   [PIPE_COUNT];
    logic [7:0]        wcnt_reg   [PIPE_COUNT];
    logic [PIPE_COUNT-1:0] in_use_reg;

    logic [PIDX_W-1:0] sel;
    logic [PIDX_W-1:0] free_idx;
    logic              found;
    logic              pipe_ok;
    logic [PIDX_W-1:0] tgt;
    logic              upd;
    logic [PTR_W-1:0]  head_next;
    logic [PTR_W-1:0]  tail_next;
    logic [FILL_W-1:0] fill_next;
    logic [7:0]        rcnt_next;
    logic [7:0]        wcnt_next;
    logic              use_next;
    logic              do_rd;
    logic              do_wr;
    mpbf_rsp_t         res_next;
    logic              load_out;
    logic              accept;

    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = 0; i < PIPE_COUNT; i++)
        begin
            if (!found && !in_use_reg[i])
            begin
                found    = 1'b1;
                free_idx = PIDX_W'(i);
            end
        end
    end

    assign sel     = PIDX_W'(req_hold_reg.pipe_index);
    assign pipe_ok = (32'(req_hold_reg.pipe_index) < PIPE_COUNT) && in_use_reg[sel];

    always_comb
    begin
        tgt       = sel;
        upd       = 1'b0;
        head_next = head_reg[sel];
        tail_next = tail_reg[sel];
        fill_next = fill_reg[sel];
        rcnt_next = rcnt_reg[sel];
        wcnt_next = wcnt_reg[sel];
        use_next  = in_use_reg[sel];
        do_rd     = 1'b0;
        do_wr     = 1'b0;
        res_next  = '0;
        res_next.status = STS_OK;

        unique case (req_hold_reg.req_type)
            REQ_ALLOC:
            begin
                tgt       = free_idx;
                upd       = found;
                head_next = '0;
                tail_next = '0;
                fill_next = '0;
                rcnt_next = 8'd1;
                wcnt_next = 8'd1;
                use_next  = 1'b1;
                if (found)
                begin
                    res_next.pipe_out = 2'(free_idx);
                end
                else
                begin
                    res_next.status = STS_NOFREE;
                end
            end
            REQ_WRITE:
            begin
                if (!pipe_ok)
                begin
                    res_next.status = STS_NOTUSED;
                end
                else if (rcnt_reg[sel] == 8'd0)
                begin
                    res_next.status = STS_BROKEN;
                end
                else if (fill_reg[sel] == FILL_W'(PIPE_DEPTH))
                begin
                    res_next.status = STS_BLOCK;
                end
                else
                begin
                    upd       = 1'b1;
                    do_wr     = 1'b1;
                    tail_next = (tail_reg[sel] == PTR_W'(PIPE_DEPTH - 1)) ? '0
                                : tail_reg[sel] + PTR_W'(1);
                    fill_next = fill_reg[sel] + FILL_W'(1);
                    res_next.wake_readers = 1'b1;
                end
            end
            REQ_READ:
            begin
                if (!pipe_ok)
                begin
                    res_next.status = STS_NOTUSED;
                end
                else if (fill_reg[sel] == '0)
                begin
                    res_next.status = (wcnt_reg[sel] == 8'd0) ? STS_EOF : STS_BLOCK;
                end
                else
                begin
                    upd       = 1'b1;
                    do_rd     = 1'b1;
                    head_next = (head_reg[sel] == PTR_W'(PIPE_DEPTH - 1)) ? '0
                                : head_reg[sel] + PTR_W'(1);
                    fill_next = fill_reg[sel] - FILL_W'(1);
                    res_next.wake_writers = 1'b1;
                end
            end
            REQ_ACQUIRE:
            begin
                if (!pipe_ok)
                begin
                    res_next.status = STS_NOTUSED;
                end
                else
                begin
                    upd = 1'b1;
                    if (req_hold_reg.end_is_writer)
                    begin
                        if (wcnt_reg[sel] != END_MAX)
                        begin
                            wcnt_next = wcnt_reg[sel] + 8'd1;
                        end
                    end
                    else if (rcnt_reg[sel] != END_MAX)
                    begin
                        rcnt_next = rcnt_reg[sel] + 8'd1;
                    end
                end
            end
            REQ_RELEASE:
            begin
                if (!pipe_ok)
                begin
                    res_next.status = STS_NOTUSED;
                end
                else
                begin
                    upd = 1'b1;
                    if (req_hold_reg.end_is_writer)
                    begin
                        if (wcnt_reg[sel] != 8'd0)
                        begin
                            wcnt_next = wcnt_reg[sel] - 8'd1;
                        end
                        res_next.wake_readers = (wcnt_next == 8'd0);
                    end
                    else
                    begin
                        if (rcnt_reg[sel] != 8'd0)
                        begin
                            rcnt_next = rcnt_reg[sel] - 8'd1;
                        end
                        res_next.wake_writers = (rcnt_next == 8'd0);
                    end
                    if (rcnt_next == 8'd0 && wcnt_next == 8'd0)
                    begin
                        head_next = '0;
                        tail_next = '0;
                        fill_next = '0;
                        use_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                res_next.status = STS_OK;
            end
        endcase
    end

    assign mem_addr  = ADDR_W'(32'(sel) * 32'(PIPE_DEPTH)
                       + 32'(do_wr ? tail_reg[sel] : head_reg[sel]));
    assign mem_wdata = req_hold_reg.write_data;

    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        accept     = 1'b0;
        load_out   = 1'b0;
        mem_cmd    = '0;
        unique case (state_reg)
            FSM_IDLE:
            begin
                req_stall = 1'b0;
                accept    = req_valid;
                if (req_valid)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                mem_cmd.rd = do_rd;
                mem_cmd.wr = do_wr;
                state_next = FSM_DONE;
            end
            FSM_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    load_out   = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            rsp_valid_reg <= 1'b0;
            in_use_reg    <= '0;
            for (int i = 0; i < PIPE_COUNT; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
                rcnt_reg[i] <= '0;
                wcnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (state_reg == FSM_EXEC && upd)
            begin
                head_reg[tgt]   <= head_next;
                tail_reg[tgt]   <= tail_next;
                fill_reg[tgt]   <= fill_next;
                rcnt_reg[tgt]   <= rcnt_next;
                wcnt_reg[tgt]   <= wcnt_next;
                in_use_reg[tgt] <= use_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_hold_reg <= req;
        end
        if (state_reg == FSM_EXEC)
        begin
            res_reg   <= res_next;
            rd_ok_reg <= do_rd;
        end
        if (load_out)
        begin
            rsp_reg <= {res_reg.status, rd_ok_reg ? mem_rdata : 8'd0, res_reg.pipe_out,
                        res_reg.wake_readers, res_reg.wake_writers};
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: rtl/core/mpbf_checker.sv
module mpbf_checker
    import mpbf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input mpbf_rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("Stalled response changed.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("Request taken while the previous transaction was in flight.");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status <= STS_NOTUSED)
        else $error("Response status out of range.");

    a_data_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.read_data != 8'd0 || rsp.pipe_out != 2'd0)
        |-> rsp.status == STS_OK)
        else $error("Data or pipe returned with a failing status.");

    a_wake_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.wake_readers && rsp.wake_writers))
        else $error("Both wake flags raised by one transaction.");

endmodule

bind multi_pipe_byte_fifo mpbf_checker u_mpbf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// File: test/testbench.sv
module testbench;
    import mpbf_pkg::*;

    localparam int PIPES = 4;
    localparam int DEPTH = 1024;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [2:0] REQ_IGNORED_LO = 3'd5;
    localparam logic [2:0] REQ_IGNORED_HI = 3'd7;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    mpbf_req_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    mpbf_rsp_t rsp;

    mpbf_req_t request_backlog[$];
    mpbf_rsp_t expected_responses[$];

    logic [7:0]  pipe_bytes [PIPES * DEPTH];
    logic [9:0]  head_ptr   [PIPES];
    logic [9:0]  tail_ptr   [PIPES];
    logic [10:0] fill_count [PIPES];
    logic [7:0]  reader_cnt [PIPES];
    logic [7:0]  writer_cnt [PIPES];
    bit          pipe_busy  [PIPES];

    int mismatches = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int mode_left = 0;

    multi_pipe_byte_fifo dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void clear_pipe(input int p);
        head_ptr[p] = '0;
        tail_ptr[p] = '0;
        fill_count[p] = '0;
    endfunction

    function automatic mpbf_rsp_t serve_request(input mpbf_req_t r);
        mpbf_rsp_t res;
        int p;
        bit taken;
        res = '0;
        p = r.pipe_index;
        taken = 1'b0;
        case (r.req_type)
            REQ_ALLOC:
            begin
                res.status = STS_NOFREE;
                for (int i = 0; i < PIPES; i++)
                begin
                    if (!taken && !pipe_busy[i])
                    begin
                        taken = 1'b1;
                        clear_pipe(i);
                        pipe_busy[i] = 1'b1;
                        reader_cnt[i] = 8'd1;
                        writer_cnt[i] = 8'd1;
                        res.status = STS_OK;
                        res.pipe_out = 2'(i);
                    end
                end
            end
            REQ_WRITE, REQ_READ, REQ_ACQUIRE, REQ_RELEASE:
            begin
                if (!pipe_busy[p])
                    res.status = STS_NOTUSED;
                else if (r.req_type == REQ_WRITE)
                begin
                    if (reader_cnt[p] == 8'd0)
                        res.status = STS_BROKEN;
                    else if (fill_count[p] >= DEPTH)
                        res.status = STS_BLOCK;
                    else
                    begin
                        pipe_bytes[p * DEPTH + tail_ptr[p]] = r.write_data;
                        tail_ptr[p] = (tail_ptr[p] == DEPTH - 1) ? '0 : tail_ptr[p] + 10'd1;
                        fill_count[p] = fill_count[p] + 11'd1;
                        res.wake_readers = 1'b1;
                    end
                end
                else if (r.req_type == REQ_READ)
                begin
                    if (fill_count[p] == 11'd0)
                        res.status = (writer_cnt[p] == 8'd0) ? STS_EOF : STS_BLOCK;
                    else
                    begin
                        res.read_data = pipe_bytes[p * DEPTH + head_ptr[p]];
                        head_ptr[p] = (head_ptr[p] == DEPTH - 1) ? '0 : head_ptr[p] + 10'd1;
                        fill_count[p] = fill_count[p] - 11'd1;
                        res.wake_writers = 1'b1;
                    end
                end
                else if (r.req_type == REQ_ACQUIRE)
                begin
                    if (r.end_is_writer)
                    begin
                        if (writer_cnt[p] != END_MAX)
                            writer_cnt[p] = writer_cnt[p] + 8'd1;
                    end
                    else if (reader_cnt[p] != END_MAX)
                        reader_cnt[p] = reader_cnt[p] + 8'd1;
                end
                else
                begin
                    if (r.end_is_writer)
                    begin
                        if (writer_cnt[p] != 8'd0)
                            writer_cnt[p] = writer_cnt[p] - 8'd1;
                        if (writer_cnt[p] == 8'd0)
                            res.wake_readers = 1'b1;
                    end
                    else
                    begin
                        if (reader_cnt[p] != 8'd0)
                            reader_cnt[p] = reader_cnt[p] - 8'd1;
                        if (reader_cnt[p] == 8'd0)
                            res.wake_writers = 1'b1;
                    end
                    if (reader_cnt[p] == 8'd0 && writer_cnt[p] == 8'd0)
                    begin
                        clear_pipe(p);
                        pipe_busy[p] = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic void send(input logic [2:0] kind, input logic [1:0] pipe,
                                 input logic writer, input logic [7:0] data);
        mpbf_req_t r;
        r.req_type = kind;
        r.pipe_index = pipe;
        r.end_is_writer = writer;
        r.write_data = data;
        request_backlog.push_back(r);
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic wait_idle();
        while (request_backlog.size() != 0 || req_valid || expected_responses.size() != 0)
            @(negedge clk);
    endtask

    task automatic queue_mix(input int count);
        int busy_list[$];
        int k;
        logic [1:0] pipe;
        for (int n = 0; n < count; n++)
        begin
            while (request_backlog.size() >= 4)
                @(negedge clk);
            busy_list.delete();
            for (int i = 0; i < PIPES; i++)
                if (pipe_busy[i])
                    busy_list.push_back(i);
            if (busy_list.size() != 0 && $urandom_range(0, 9) != 0)
                pipe = 2'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
            else
                pipe = 2'($urandom_range(0, 3));
            k = $urandom_range(0, 99);
            if (k < 8)
                send(REQ_ALLOC, pipe, 1'($urandom), 8'($urandom));
            else if (k < 40)
                send(REQ_WRITE, pipe, 1'($urandom), 8'($urandom));
            else if (k < 72)
                send(REQ_READ, pipe, 1'($urandom), 8'($urandom));
            else if (k < 82)
                send(REQ_ACQUIRE, pipe, 1'($urandom), 8'($urandom));
            else if (k < 96)
                send(REQ_RELEASE, pipe, 1'($urandom), 8'($urandom));
            else
                send(3'($urandom_range(REQ_IGNORED_LO, REQ_IGNORED_HI)), pipe,
                     1'($urandom), 8'($urandom));
        end
    endtask

    // Fills one pipe past full, so the write pointer wraps, and then drains part of it.
    task automatic fill_and_drain();
        int p;
        int n;
        p = -1;
        for (int i = 0; i < PIPES; i++)
            if (p < 0 && pipe_busy[i] && reader_cnt[i] != 8'd0)
                p = i;
        if (p < 0)
        begin
            for (int i = 0; i < PIPES; i++)
                if (p < 0 && !pipe_busy[i])
                    p = i;
            if (p >= 0)
                send(REQ_ALLOC, 2'd0, 1'b0, 8'd0);
            else
            begin
                p = 0;
                send(REQ_ACQUIRE, 2'd0, 1'b0, 8'd0);
            end
        end
        n = DEPTH - int'(fill_count[p]) + 2;
        repeat (n)
            send(REQ_WRITE, 2'(p), 1'($urandom), 8'($urandom));
        repeat (400)
            send(REQ_READ, 2'(p), 1'($urandom), 8'($urandom));
        send(REQ_RELEASE, 2'(p), 1'b1, 8'($urandom));
        send(REQ_READ, 2'(p), 1'b0, 8'($urandom));
    endtask

    task automatic saturate_readers();
        int p;
        int n;
        p = -1;
        for (int i = 0; i < PIPES; i++)
            if (p < 0 && pipe_busy[i])
                p = i;
        if (p < 0)
        begin
            p = 0;
            n = 1;
            send(REQ_ALLOC, 2'd0, 1'b0, 8'd0);
        end
        else
            n = int'(reader_cnt[p]);
        repeat (int'(END_MAX) - n + 2)
            send(REQ_ACQUIRE, 2'(p), 1'b0, 8'($urandom));
    endtask

    initial
    begin
        for (int i = 0; i < PIPES; i++)
        begin
            clear_pipe(i);
            reader_cnt[i] = '0;
            writer_cnt[i] = '0;
            pipe_busy[i] = 1'b0;
        end

        send(REQ_WRITE, 2'd0, 1'b0, 8'h5A);
        send(REQ_READ, 2'd3, 1'b1, 8'h00);
        send(REQ_IGNORED_HI, 2'd3, 1'b1, 8'hFF);
        send(REQ_IGNORED_LO, 2'd1, 1'b0, 8'h81);
        repeat (5)
            send(REQ_ALLOC, 2'd2, 1'b1, 8'h00);
        send(REQ_READ, 2'd0, 1'b0, 8'h00);
        send(REQ_WRITE, 2'd0, 1'b0, 8'h00);
        send(REQ_WRITE, 2'd0, 1'b1, 8'hFF);
        send(REQ_WRITE, 2'd0, 1'b0, 8'hA5);
        send(REQ_READ, 2'd0, 1'b0, 8'h00);
        send(REQ_READ, 2'd0, 1'b0, 8'h00);
        send(REQ_RELEASE, 2'd0, 1'b1, 8'h00);
        send(REQ_READ, 2'd0, 1'b0, 8'h00);
        send(REQ_READ, 2'd0, 1'b0, 8'h00);
        send(REQ_RELEASE, 2'd0, 1'b1, 8'h00);
        send(REQ_RELEASE, 2'd1, 1'b0, 8'h00);
        send(REQ_WRITE, 2'd1, 1'b0, 8'h3C);
        send(REQ_ACQUIRE, 2'd1, 1'b0, 8'h00);
        send(REQ_ACQUIRE, 2'd2, 1'b1, 8'h00);
        send(REQ_RELEASE, 2'd0, 1'b0, 8'h00);
        send(REQ_ALLOC, 2'd3, 1'b0, 8'h00);

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_mix(80);
        wait_idle();
        fill_and_drain();
        queue_mix(50);
        wait_idle();
        saturate_readers();
        queue_mix(70);
        wait_idle();
        repeat (10)
            @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        mpbf_req_t next_req;
        logic next_valid;
        int k;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            next_valid = req_valid;
            next_req = req;
            if (req_valid && !req_stall)
            begin
                expected_responses.push_back(serve_request(req));
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (request_backlog.size() != 0)
                begin
                    next_req = request_backlog.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        k = $urandom_range(0, 19);
                        if (k < 8)
                            gap_left = 0;
                        else if (k < 18)
                            gap_left = $urandom_range(1, 6);
                        else
                            gap_left = $urandom_range(10, 20);
                    end
                end
            end
            req_valid <= next_valid;
            req <= next_req;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        mpbf_rsp_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_mode = 0;
            mode_left = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_responses.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: response mismatch: expected none, actual %h", $time, rsp);
                end
                else
                begin
                    want = expected_responses.pop_front();
                    compare_field("status", 8'(want.status), 8'(rsp.status));
                    compare_field("read_data", want.read_data, rsp.read_data);
                    compare_field("pipe_out", 8'(want.pipe_out), 8'(rsp.pipe_out));
                    compare_field("wake_readers", 8'(want.wake_readers),
                                  8'(rsp.wake_readers));
                    compare_field("wake_writers", 8'(want.wake_writers),
                                  8'(rsp.wake_writers));
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 160);
            end
            else
                mode_left--;
            case (stall_mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= ($urandom_range(0, 3) == 0);
                2: rsp_stall <= ($urandom_range(0, 3) != 0);
                default: rsp_stall <= ((mode_left % 8) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

// File: sim.f
rtl/core/mpbf_pkg.sv
rtl/core/mpbf_store.sv
rtl/core/mpbf_ctrl.sv
rtl/core/multi_pipe_byte_fifo.sv
rtl/core/mpbf_checker.sv
test/testbench.sv
